### design/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg: shared types and constants of the bilinear sub-pixel shift unit
// Configuration layout, register indexes and the queue entry that passes
// from the front part to the arithmetic back part.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

    // Width of one image byte.
    localparam int PIXEL_W = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAC_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 2'd3;

    // Depth of the queue between front and back, and the width of its level.
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [3:0]  frac_x;
        logic [3:0]  frac_y;
        logic [2:0]  channels;
        logic [12:0] row_bytes;
    } bss_cfg_t;

    // One classified item: the four neighbours and the end-of-row flag.
    typedef struct packed {
        logic [PIXEL_W-1:0] top_left;
        logic [PIXEL_W-1:0] top_right;
        logic [PIXEL_W-1:0] bot_left;
        logic [PIXEL_W-1:0] bot_right;
        logic               row_end;
    } bss_entry_t;

endpackage

`default_nettype wire

### design/bss_stream_if.sv
// ----------------------------------------------------------------------------
// bss_stream_if: stream channels of the bilinear sub-pixel shift unit
// Source byte channel and destination byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bss_in_if
    import bss_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_in;
    logic               frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface bss_out_if
    import bss_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_out;
    logic               row_end;

    modport source (output valid, output pixel_out, output row_end, input ready);
    modport sink   (input valid, input pixel_out, input row_end, output ready);
endinterface

`default_nettype wire

### design/bilinear_subpixel_shift_unit.sv
// ----------------------------------------------------------------------------
// bilinear_subpixel_shift_unit: streaming bilinear sub-pixel image shift
// Takes source bytes row by row and emits each destination byte as the
// weighted mean of its four neighbours in the current and previous rows.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                         Transfer when
//  in_ch     sink       pixel_in[7:0], frame_start      valid && ready
//  out_ch    source     pixel_out[7:0], row_end         valid && ready
//  cfg       write      cfg_index[1:0], cfg_data[12:0]  cfg_we
//
//  One source byte is taken per cycle while in_ch ready is high; the line
//  buffer RAM reads and writes one entry per byte, which sets that rate.
//  A destination byte passes the line buffer read, the queue, the products
//  and the rounded sum before it leaves.
//  A stalled output fills the four-entry queue; the input then holds ready
//  low until the back part drains.
//  Reset clears the control state; the line buffer is not cleared.
//
`default_nettype none

module bilinear_subpixel_shift_unit
    import bss_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 4096,
    parameter int MAX_CHANNELS  = 4,
    parameter int FRAC_BITS     = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    bss_in_if.sink                     in_ch,
    bss_out_if.source                  out_ch
);

    bss_cfg_t          cfg_reg;
    logic              push;
    bss_entry_t        push_entry;
    logic              pop;
    bss_entry_t        pop_entry;
    logic              q_not_empty;
    logic [QCNT_W-1:0] q_level;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frac_x    <= 4'd0;
            cfg_reg.frac_y    <= 4'd0;
            cfg_reg.channels  <= 3'd1;
            cfg_reg.row_bytes <= 13'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAC_X:    cfg_reg.frac_x    <= cfg_data[3:0];
                CFG_FRAC_Y:    cfg_reg.frac_y    <= cfg_data[3:0];
                CFG_CHANNELS:  cfg_reg.channels  <= cfg_data[2:0];
                CFG_ROW_BYTES: cfg_reg.row_bytes <= cfg_data[12:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // Front part: column tracking and line buffer.
    bss_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_CHANNELS  (MAX_CHANNELS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_ch.valid),
        .in_pixel       (in_ch.pixel_in),
        .in_frame_start (in_ch.frame_start),
        .in_ready       (in_ch.ready),
        .queue_level    (q_level),
        .push           (push),
        .push_entry     (push_entry)
    );

    // Queue between the two parts.
    bss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .pop_data  (pop_entry),
        .not_empty (q_not_empty),
        .level     (q_level)
    );

    // Back part: weighting and output register.
    bss_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_not_empty),
        .q_data      (pop_entry),
        .q_pop       (pop),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_pixel   (out_ch.pixel_out),
        .out_row_end (out_ch.row_end)
    );

endmodule

`default_nettype wire

### design/bss_ram.sv
// ----------------------------------------------------------------------------
// bss_ram: generic single-clock RAM
// One write port and one read port; registered read data that returns the
// old contents when the same entry is written in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4100
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read in one process so that a read sees the previous contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/bss_front.sv
// ----------------------------------------------------------------------------
// bss_front: column tracking, line buffer and neighbour delay lines
// Accepts source bytes, keeps the previous row, gathers the four neighbours
// and pushes one queue entry for every byte that yields a destination byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_front
    import bss_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 4096,
    parameter int MAX_CHANNELS  = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bss_cfg_t           cfg,
    input  wire logic               in_valid,
    input  wire logic [PIXEL_W-1:0] in_pixel,
    input  wire logic               in_frame_start,
    output logic                    in_ready,
    input  wire logic [QCNT_W-1:0]  queue_level,
    output logic                    push,
    output bss_entry_t              push_entry
);

    localparam int LINE_DEPTH = MAX_ROW_BYTES + MAX_CHANNELS;
    localparam int AW         = $clog2(LINE_DEPTH);
    localparam int COL_W      = $clog2(LINE_DEPTH + 1);
    localparam int LW         = (COL_W > CFG_DATA_W) ? COL_W : CFG_DATA_W;
    localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Effective geometry, clamped from the registers.
    logic [2:0]       ch_eff;
    logic [COL_W-1:0] len;
    logic [LW-1:0]    rb_ext;
    logic [LW-1:0]    rb_eff;

    // Column position within the source row.
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             past_first_reg;
    logic             past_first_next;

    logic             accept;
    logic [COL_W-1:0] col_start;
    logic             pf_start;
    logic [COL_W-1:0] col_cur;
    logic             pf_cur;
    logic [COL_W-1:0] col_inc;
    logic             emit;
    logic             row_end;

    // Item waiting for its line buffer read.
    logic               s1_valid_reg;
    logic [PIXEL_W-1:0] s1_pixel_reg;
    logic               s1_emit_reg;
    logic               s1_row_end_reg;

    logic [PIXEL_W-1:0] top_pixel;
    logic [PIXEL_W-1:0] prev_dly_reg [MAX_CHANNELS];
    logic [PIXEL_W-1:0] cur_dly_reg  [MAX_CHANNELS];
    logic [CH_W-1:0]    ch_idx;
    logic [QCNT_W:0]    level_sum;

    // Clamp channels and row length to their supported ranges.
    always_comb
    begin
        if (cfg.channels == 3'd0)
        begin
            ch_eff = 3'd1;
        end
        else if (cfg.channels > 3'(MAX_CHANNELS))
        begin
            ch_eff = 3'(MAX_CHANNELS);
        end
        else
        begin
            ch_eff = cfg.channels;
        end

        rb_ext = LW'(cfg.row_bytes);
        if (rb_ext == '0)
        begin
            rb_eff = LW'(1);
        end
        else if (rb_ext > LW'(MAX_ROW_BYTES))
        begin
            rb_eff = LW'(MAX_ROW_BYTES);
        end
        else
        begin
            rb_eff = rb_ext;
        end
        len = COL_W'(rb_eff) + COL_W'(ch_eff);
    end

    // Room is reserved for the item still waiting for its line buffer read.
    assign level_sum = (QCNT_W + 1)'(queue_level) + (QCNT_W + 1)'(s1_valid_reg);
    assign in_ready  = level_sum < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept    = in_valid && in_ready;

    // Column of the incoming byte after frame start and row wrap.
    always_comb
    begin
        col_start = in_frame_start ? '0 : col_reg;
        pf_start  = in_frame_start ? 1'b0 : past_first_reg;
        if (col_start >= len)
        begin
            col_cur = '0;
            pf_cur  = 1'b1;
        end
        else
        begin
            col_cur = col_start;
            pf_cur  = pf_start;
        end
        emit    = pf_cur && (col_cur >= COL_W'(ch_eff));
        row_end = (col_cur == len - COL_W'(1));
        col_inc = col_cur + COL_W'(1);
        if (col_inc >= len)
        begin
            col_next        = '0;
            past_first_next = 1'b1;
        end
        else
        begin
            col_next        = col_inc;
            past_first_next = pf_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            past_first_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg        <= col_next;
            past_first_reg <= past_first_next;
        end
    end

    // Line buffer: read the byte above and store the new byte in one transfer.
    bss_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_cur[AW-1:0]),
        .wdata (in_pixel),
        .re    (accept),
        .raddr (col_cur[AW-1:0]),
        .rdata (top_pixel)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg   <= in_pixel;
            s1_emit_reg    <= emit;
            s1_row_end_reg <= row_end;
        end
    end

    // Delay lines hold the last bytes of the current and previous rows.
    assign ch_idx = CH_W'(ch_eff - 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                prev_dly_reg[i] <= '0;
                cur_dly_reg[i]  <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            for (int i = MAX_CHANNELS - 1; i > 0; i--)
            begin
                prev_dly_reg[i] <= prev_dly_reg[i-1];
                cur_dly_reg[i]  <= cur_dly_reg[i-1];
            end
            prev_dly_reg[0] <= top_pixel;
            cur_dly_reg[0]  <= s1_pixel_reg;
        end
    end

    // Queue entry for a byte that yields a result.
    assign push                 = s1_valid_reg && s1_emit_reg;
    assign push_entry.top_left  = prev_dly_reg[ch_idx];
    assign push_entry.top_right = top_pixel;
    assign push_entry.bot_left  = cur_dly_reg[ch_idx];
    assign push_entry.bot_right = s1_pixel_reg;
    assign push_entry.row_end   = s1_row_end_reg;

endmodule

`default_nettype wire

### design/bss_queue.sv
// ----------------------------------------------------------------------------
// bss_queue: short queue between the front and back parts
// Holds classified items in flip-flops; the front never pushes into a full
// queue because its ready accounts for the level.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_queue
    import bss_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire bss_entry_t       push_data,
    input  wire logic             pop,
    output bss_entry_t            pop_data,
    output logic                  not_empty,
    output logic [QCNT_W-1:0]     level
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    bss_entry_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0] level_reg;

    assign pop_data  = slot_reg[rd_ptr_reg];
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers wrap at the queue depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   level_reg <= level_reg + QCNT_W'(1);
                2'b01:   level_reg <= level_reg - QCNT_W'(1);
                default: level_reg <= level_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

### design/bss_back.sv
// ----------------------------------------------------------------------------
// bss_back: weighting of the four neighbours and the output register
// Two stages: four products of byte by weight, then the rounded sum.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_back
    import bss_pkg::*;
#(
    parameter int FRAC_BITS = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bss_cfg_t           cfg,
    input  wire logic               q_valid,
    input  wire bss_entry_t         q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [PIXEL_W-1:0]      out_pixel,
    output logic                    out_row_end
);

    localparam int F_W   = FRAC_BITS + 1;
    localparam int WP_W  = 2 * F_W;
    localparam int WT_W  = 2 * FRAC_BITS + 1;
    localparam int PR_W  = PIXEL_W + WT_W;
    localparam int SUM_W = PR_W + 2;
    localparam logic [F_W-1:0]   RANGE = F_W'(1) << FRAC_BITS;
    localparam logic [SUM_W-1:0] ROUND = SUM_W'(1) << (2 * FRAC_BITS - 1);

    logic [F_W-1:0]  fx;
    logic [F_W-1:0]  fy;
    logic [F_W-1:0]  gx;
    logic [F_W-1:0]  gy;
    logic [WP_W-1:0] w_tl_full;
    logic [WP_W-1:0] w_tr_full;
    logic [WP_W-1:0] w_bl_full;
    logic [WP_W-1:0] w_br_full;
    logic [WT_W-1:0] w_tl_reg;
    logic [WT_W-1:0] w_tr_reg;
    logic [WT_W-1:0] w_bl_reg;
    logic [WT_W-1:0] w_br_reg;

    logic            p_valid_reg;
    logic            p_row_end_reg;
    logic [PR_W-1:0] p_tl_reg;
    logic [PR_W-1:0] p_tr_reg;
    logic [PR_W-1:0] p_bl_reg;
    logic [PR_W-1:0] p_br_reg;

    logic               out_valid_reg;
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic               out_row_end_reg;

    logic             out_free;
    logic             p_free;
    logic [SUM_W-1:0] sum;

    // Weights follow the fractions; registered so each stage has one multiply.
    assign fx        = F_W'(cfg.frac_x[FRAC_BITS-1:0]);
    assign fy        = F_W'(cfg.frac_y[FRAC_BITS-1:0]);
    assign gx        = RANGE - fx;
    assign gy        = RANGE - fy;
    assign w_tl_full = WP_W'(gx) * WP_W'(gy);
    assign w_tr_full = WP_W'(fx) * WP_W'(gy);
    assign w_bl_full = WP_W'(gx) * WP_W'(fy);
    assign w_br_full = WP_W'(fx) * WP_W'(fy);

    always_ff @(posedge clk)
    begin
        w_tl_reg <= w_tl_full[WT_W-1:0];
        w_tr_reg <= w_tr_full[WT_W-1:0];
        w_bl_reg <= w_bl_full[WT_W-1:0];
        w_br_reg <= w_br_full[WT_W-1:0];
    end

    // Pipeline flow control.
    assign out_free = !out_valid_reg || out_ready;
    assign p_free   = !p_valid_reg || out_free;
    assign q_pop    = q_valid && p_free;

    // Product stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (p_free)
        begin
            p_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            p_tl_reg      <= PR_W'(q_data.top_left) * PR_W'(w_tl_reg);
            p_tr_reg      <= PR_W'(q_data.top_right) * PR_W'(w_tr_reg);
            p_bl_reg      <= PR_W'(q_data.bot_left) * PR_W'(w_bl_reg);
            p_br_reg      <= PR_W'(q_data.bot_right) * PR_W'(w_br_reg);
            p_row_end_reg <= q_data.row_end;
        end
    end

    // Rounded sum; the weights add up to the full range, so it fits a byte.
    assign sum = SUM_W'(p_tl_reg) + SUM_W'(p_tr_reg) + SUM_W'(p_bl_reg)
               + SUM_W'(p_br_reg) + ROUND;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && p_valid_reg)
        begin
            out_pixel_reg   <= sum[2*FRAC_BITS +: PIXEL_W];
            out_row_end_reg <= p_row_end_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_pixel   = out_pixel_reg;
    assign out_row_end = out_row_end_reg;

endmodule

`default_nettype wire

### design/bss_checker.sv
// ----------------------------------------------------------------------------
// bss_checker: port-level checks of the bilinear sub-pixel shift unit
// Output handshake rules, input readiness once the pipeline has drained,
// and no result appearing from an empty pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_checker
    import bss_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [PIXEL_W-1:0] pixel_out,
    input wire logic               row_end
);

    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    // A waiting result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result withdrawn while stalled");

    // A waiting result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(pixel_out) && $stable(row_end)))
        else $error("result changed while stalled");

    // With no result shown for a while the queue is empty, so the input is ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !$past(out_valid, 1) && !$past(out_valid, 2)
         && !$past(out_valid, 3)) |-> in_ready)
        else $error("input refused although the pipeline has drained");

    // A result needs a source byte that was taken earlier and has passed the pipeline registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(out_valid, 1) && !$past(out_valid, 2) && !$past(out_valid, 3)
         && !$past(out_valid, 4) && !$past(in_xfer, 1) && !$past(in_xfer, 2)
         && !$past(in_xfer, 3) && !$past(in_xfer, 4) && !$past(in_xfer, 5))
        |-> !out_valid)
        else $error("result appeared from an empty pipeline");

endmodule

bind bilinear_subpixel_shift_unit bss_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .pixel_out (out_ch.pixel_out),
    .row_end   (out_ch.row_end)
);

`default_nettype wire
